>>> hdl/spq_pkg.sv
package spq_pkg;

  // Fixed widths of the stream payloads, set by the field widths of the block.
  localparam int FIELD_W     = 32;
  localparam int KIND_W      = 2;
  localparam int LIMIT_W     = 7;
  localparam int COUNT_OUT_W = 7;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 112;

  // Bit positions of the result fields inside the output tdata.
  localparam int OUT_VAL_LSB    = 0;
  localparam int OUT_PRI_LSB    = 32;
  localparam int OUT_EMPTY_BIT  = 64;
  localparam int OUT_FULL_BIT   = 65;
  localparam int OUT_STATUS_LSB = 66;
  localparam int OUT_COUNT_LSB  = 68;
  localparam int OUT_COMP_LSB   = 75;

  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_INS_FRONT,
    S_SHIFT,
    S_FRONT_RD,
    S_RESULT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    take_item;    // latch the input beat
    logic    scan_start;   // read the tail entry, index at the tail
    logic    scan_move;    // move the entry read one place back, step towards the front
    logic    ins_next;     // write the new entry just behind the entry read
    logic    move_front;   // move the front entry to place one
    logic    ins_zero;     // write the new entry at the front
    logic    shift_start;  // read place one for a dequeue
    logic    shift_move;   // move the entry read one place forward
    logic    count_dec;    // one entry fewer
    logic    front_read;   // read the front entry
    logic    result_load;  // load the output register
    status_e result_status;
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              empty;
    logic              full;
    logic              one_left;
    logic              at_zero;
    logic              key_ge;
    logic              key_gt;
    logic              shift_last;
    logic              slot_free;
  } spq_stat_t;

endpackage

>>> hdl/spq_ctrl.sv
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_cmd_t  cmd_o
);

  spq_pkg::state_e  state_q, state_d;
  spq_pkg::status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::S_IDLE;
      st_q    <= spq_pkg::ST_DONE;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::S_IDLE: begin
        if (in_valid_i) state_d = spq_pkg::S_DECODE;
      end
      spq_pkg::S_DECODE: begin
        state_d = spq_pkg::S_FRONT_RD;
        if (stat_i.kind == spq_pkg::KIND_ENQ) begin
          if (!stat_i.full && !stat_i.empty) state_d = spq_pkg::S_SCAN;
        end else if (stat_i.kind == spq_pkg::KIND_DEQ) begin
          if (!stat_i.empty && !stat_i.one_left) state_d = spq_pkg::S_SHIFT;
        end
      end
      spq_pkg::S_SCAN: begin
        if (stat_i.at_zero) begin
          state_d = stat_i.key_gt ? spq_pkg::S_INS_FRONT : spq_pkg::S_FRONT_RD;
        end else if (!stat_i.key_ge) begin
          state_d = spq_pkg::S_FRONT_RD;
        end
      end
      spq_pkg::S_INS_FRONT: begin
        state_d = spq_pkg::S_FRONT_RD;
      end
      spq_pkg::S_SHIFT: begin
        if (stat_i.shift_last) state_d = spq_pkg::S_FRONT_RD;
      end
      spq_pkg::S_FRONT_RD: begin
        state_d = spq_pkg::S_RESULT;
      end
      spq_pkg::S_RESULT: begin
        if (stat_i.slot_free) state_d = spq_pkg::S_IDLE;
      end
      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o               = '0;
    cmd_o.result_status = st_q;
    st_d                = st_q;
    in_ready_o          = 1'b0;
    case (state_q)
      spq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          st_d            = spq_pkg::ST_DONE;
        end
      end
      spq_pkg::S_DECODE: begin
        if (stat_i.kind == spq_pkg::KIND_ENQ) begin
          if (stat_i.full) begin
            st_d = spq_pkg::ST_REFUSED;
          end else if (stat_i.empty) begin
            cmd_o.ins_zero = 1'b1;
          end else begin
            cmd_o.scan_start = 1'b1;
          end
        end else if (stat_i.kind == spq_pkg::KIND_DEQ) begin
          if (stat_i.empty) begin
            st_d = spq_pkg::ST_IGNORED;
          end else if (stat_i.one_left) begin
            cmd_o.count_dec = 1'b1;
          end else begin
            cmd_o.shift_start = 1'b1;
          end
        end
      end
      spq_pkg::S_SCAN: begin
        if (stat_i.at_zero) begin
          if (stat_i.key_gt) cmd_o.move_front = 1'b1;
          else               cmd_o.ins_next   = 1'b1;
        end else if (stat_i.key_ge) begin
          cmd_o.scan_move = 1'b1;
        end else begin
          cmd_o.ins_next = 1'b1;
        end
      end
      spq_pkg::S_INS_FRONT: begin
        cmd_o.ins_zero = 1'b1;
      end
      spq_pkg::S_SHIFT: begin
        cmd_o.shift_move = 1'b1;
        cmd_o.count_dec  = stat_i.shift_last;
      end
      spq_pkg::S_FRONT_RD: begin
        cmd_o.front_read = 1'b1;
      end
      spq_pkg::S_RESULT: begin
        cmd_o.result_load = stat_i.slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> hdl/spq_dp.sv
module spq_dp #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spq_pkg::spq_cmd_t                 cmd_i,
  output spq_pkg::spq_stat_t                stat_o,
  input  logic [spq_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  logic [spq_pkg::KIND_W-1:0]        in_kind_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [spq_pkg::OUT_TDATA_W-1:0]   out_data_o,
  input  logic                              cfg_valid_i,
  input  logic [spq_pkg::LIMIT_W-1:0]       cfg_data_i
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > spq_pkg::LIMIT_W) ? CW : spq_pkg::LIMIT_W;
  localparam int EW = 2 * DATA_WIDTH;

  // Entries are stored as {priority, value}.
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata_q;

  logic [spq_pkg::KIND_W-1:0]     kind_q;
  logic [DATA_WIDTH-1:0]          item_val_q;
  logic signed [DATA_WIDTH-1:0]   item_pri_q;
  logic [CW-1:0]                  count_q, count_d;
  logic [AW-1:0]                  idx_q, idx_d;
  logic [spq_pkg::FIELD_W-1:0]    comp_q, comp_d;
  logic [spq_pkg::LIMIT_W-1:0]    limit_q;
  logic                           out_valid_q;
  logic [spq_pkg::OUT_TDATA_W-1:0] out_data_q;

  logic signed [spq_pkg::FIELD_W-1:0] in_val_s, in_pri_s;
  logic signed [DATA_WIDTH-1:0]       rd_pri;
  logic [DATA_WIDTH-1:0]              rd_val;
  logic [LW-1:0]                      lim_raw, lim_eff;
  logic                               full, empty;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] comps;
  logic          comps_en;
  logic [spq_pkg::FIELD_W:0] comp_sum;

  assign in_val_s = in_data_i[spq_pkg::FIELD_W-1:0];
  assign in_pri_s = in_data_i[spq_pkg::IN_TDATA_W-1:spq_pkg::FIELD_W];
  assign rd_val   = rdata_q[DATA_WIDTH-1:0];
  assign rd_pri   = rdata_q[EW-1:DATA_WIDTH];

  // A limit of zero acts as one, a limit above the capacity as the capacity.
  assign lim_raw = LW'(limit_q);
  always_comb begin
    lim_eff = lim_raw;
    if (lim_raw == '0)                lim_eff = LW'(1);
    else if (lim_raw > LW'(CAPACITY)) lim_eff = LW'(CAPACITY);
  end

  assign full  = LW'(count_q) >= lim_eff;
  assign empty = count_q == '0;

  always_comb begin
    stat_o            = '0;
    stat_o.kind       = kind_q;
    stat_o.empty      = empty;
    stat_o.full       = full;
    stat_o.one_left   = count_q == CW'(1);
    stat_o.at_zero    = idx_q == '0;
    stat_o.key_ge     = item_pri_q >= rd_pri;
    stat_o.key_gt     = item_pri_q > rd_pri;
    stat_o.shift_last = (CW'(idx_q) + CW'(1)) == count_q;
    stat_o.slot_free  = !out_valid_q || out_ready_i;
  end

  // Memory port selection.
  always_comb begin
    we       = 1'b0;
    waddr    = '0;
    wdata    = rdata_q;
    re       = 1'b0;
    raddr    = '0;
    idx_d    = idx_q;
    comps    = '0;
    comps_en = 1'b0;
    if (cmd_i.scan_start) begin
      re    = 1'b1;
      raddr = AW'(count_q - CW'(1));
      idx_d = raddr;
    end
    if (cmd_i.scan_move) begin
      we    = 1'b1;
      waddr = idx_q + AW'(1);
      re    = 1'b1;
      raddr = idx_q - AW'(1);
      idx_d = raddr;
    end
    if (cmd_i.ins_next) begin
      we       = 1'b1;
      waddr    = idx_q + AW'(1);
      wdata    = {item_pri_q, item_val_q};
      comps    = idx_q;
      comps_en = 1'b1;
    end
    if (cmd_i.move_front) begin
      we    = 1'b1;
      waddr = AW'(1);
    end
    if (cmd_i.ins_zero) begin
      we       = 1'b1;
      waddr    = '0;
      wdata    = {item_pri_q, item_val_q};
      comps    = empty ? '0 : AW'(1);
      comps_en = 1'b1;
    end
    if (cmd_i.shift_start) begin
      re    = 1'b1;
      raddr = AW'(1);
      idx_d = AW'(1);
    end
    if (cmd_i.shift_move) begin
      we    = 1'b1;
      waddr = idx_q - AW'(1);
      if (!stat_o.shift_last) begin
        re    = 1'b1;
        raddr = idx_q + AW'(1);
        idx_d = raddr;
      end
    end
    if (cmd_i.front_read) begin
      re    = 1'b1;
      raddr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // Count and saturating comparison total.
  assign comp_sum = {1'b0, comp_q} + (spq_pkg::FIELD_W + 1)'(comps);

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins_next || cmd_i.ins_zero) count_d = count_q + CW'(1);
    else if (cmd_i.count_dec)             count_d = count_q - CW'(1);
    comp_d = comp_q;
    if (comps_en) begin
      comp_d = comp_sum[spq_pkg::FIELD_W] ? '1 : comp_sum[spq_pkg::FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      comp_q      <= '0;
      limit_q     <= spq_pkg::LIMIT_RESET;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      comp_q  <= comp_d;
      idx_q   <= idx_d;
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (cmd_i.result_load)  out_valid_q <= 1'b1;
      else if (out_ready_i)   out_valid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      kind_q     <= in_kind_i;
      item_val_q <= DATA_WIDTH'(in_val_s);
      item_pri_q <= DATA_WIDTH'(in_pri_s);
    end
    if (cmd_i.result_load) begin
      out_data_q <= {
        5'b0,
        comp_q,
        spq_pkg::COUNT_OUT_W'(count_q),
        cmd_i.result_status,
        full,
        empty,
        empty ? 32'd0 : 32'(rd_pri[DATA_WIDTH-1:0]),
        empty ? 32'd0 : 32'(rd_val)
      };
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hdl/sorted_priority_queue.sv
// Sorted priority queue.
// Entries (value, priority) are held in descending priority order in a single
// memory, the front at place zero. Each beat on the slave stream carries one
// operation, chosen by tuser: enqueue, dequeue of the front, or peek. Each
// operation returns exactly one result beat on the master stream with the
// front entry, the empty and full flags, a status code, the entry count and
// the saturating comparison total.
// The queue limit is written through its own channel, which is always ready;
// it should only be written while no operation is in flight.
// A peek, a refused operation, an enqueue into an empty queue and a dequeue of the
// last entry go from decode straight to the front read; any other enqueue first
// scans from the tail towards the front, moving entries one place back until the
// new entry's place is found, and any other dequeue moves every entry behind the
// front one place forward. The memory moves one entry per cycle through its one
// read and one write port. One operation is worked on at a time; the next beat
// is accepted in the cycle after the result is loaded, even if it has not been
// taken. When the receiver stalls, the result is held stable and a finished
// operation waits before loading the next one.
// Reset empties the queue, clears the comparison total and sets the limit to
// 64; the memory needs no clearing pass, since unwritten places are never shown.
module sorted_priority_queue #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: item_value [31:0], item_priority [63:32]
  input  logic [spq_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: kind [1:0]
  input  logic [spq_pkg::KIND_W-1:0]      s_axis_tuser_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: front_value [31:0], front_priority [63:32], queue_empty [64],
  // queue_full [65], status [67:66], entry_count [74:68],
  // comparison_total [106:75], zero fill [111:107]
  output logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic [spq_pkg::LIMIT_W-1:0]     cfg_data_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t stat;

  // The limit register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spq_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata_i),
    .in_kind_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

>>> hdl/spq_checker.sv
module spq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_i,
  input logic                            m_axis_tvalid_i,
  input logic                            m_axis_tready_i,
  input logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i
);

  logic [1:0] res_status;
  assign res_status = m_axis_tdata_i[spq_pkg::OUT_STATUS_LSB +: 2];

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
    else $error("result beat dropped while stalled");

  // One operation at a time: the slave side closes after a beat is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_i |=> !s_axis_tready_i)
    else $error("second operation accepted while one is in flight");

  // An empty queue shows a zero front entry and a zero count.
  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tdata_i[spq_pkg::OUT_EMPTY_BIT] |->
      m_axis_tdata_i[spq_pkg::OUT_PRI_LSB + 31 : spq_pkg::OUT_VAL_LSB] == '0 &&
      m_axis_tdata_i[spq_pkg::OUT_COUNT_LSB +: spq_pkg::COUNT_OUT_W] == '0)
    else $error("empty queue shows a front entry");

  // A refused enqueue comes with the full flag, an ignored dequeue with empty.
  a_status_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |->
      (res_status != spq_pkg::ST_REFUSED || m_axis_tdata_i[spq_pkg::OUT_FULL_BIT]) &&
      (res_status != spq_pkg::ST_IGNORED || m_axis_tdata_i[spq_pkg::OUT_EMPTY_BIT]))
    else $error("status code disagrees with the queue flags");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);
